[src/dbsm_pkg.sv]
// Package for the disk block sector mapper: payload structs, job record,
// status and register index codes. No dependencies.
package dbsm_pkg;

  localparam int unsigned CHUNK_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Status codes carried on every descriptor.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_MOUNTED = 2'd1;
  localparam logic [1:0] ST_READ_ONLY   = 2'd2;
  localparam logic [1:0] ST_RANGE       = 2'd3;

  // Request kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_MOUNTED   = 3'd0;
  localparam logic [2:0] REG_READ_ONLY = 3'd1;
  localparam logic [2:0] REG_TRANSLATE = 3'd2;
  localparam logic [2:0] REG_SKEW      = 3'd3;
  localparam logic [2:0] REG_DISK_SIZE = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [2:0]         unit_id;
    logic [15:0]        block_number;
    logic [15:0]        length_bytes;
    logic [15:0]        memory_base;
    logic signed [15:0] memory_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [24:0]        disk_byte_offset;
    logic [15:0]        chunk_memory_base;
    logic signed [15:0] chunk_memory_offset;
    logic [8:0]         chunk_bytes;
    logic               last;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [1:0]  status;
    logic        single;
    logic        xlate;
    logic [12:0] track;
    logic [3:0]  sector;
    logic [14:0] length;
    logic [15:0] memory_base;
    logic [15:0] memory_offset;
  } job_t;

  // Handshake between a producer and the job queue.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

[src/dbsm_front.sv]
// Front end: accepts requests, checks them and builds a job record.
// Depends on dbsm_pkg.
module dbsm_front #(
  parameter int unsigned UNIT_COUNT = 8,
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dbsm_pkg::in_item_t in_item,
  input  logic [7:0]        mounted_units,
  input  logic [7:0]        read_only_units,
  input  logic [7:0]        translate_units,
  input  logic [25:0]       disk_size_bytes,
  input  logic              q_full,
  output logic              push_valid,
  output dbsm_pkg::job_t    push_job
);
  import dbsm_pkg::*;

  logic        job_valid_r, job_valid_nxt;
  job_t        job_r, job_nxt;
  logic        accept;
  logic        unit_ok;
  logic [26:0] end_byte;
  logic        too_long;
  logic [1:0]  status;

  assign in_stall   = job_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = job_valid_r;
  assign push_job   = job_r;

  // Checks in priority order: mounted, read-only, disk size, chunk count.
  always_comb begin
    unit_ok  = ({1'b0, in_item.unit_id} < 4'(UNIT_COUNT))
               && mounted_units[in_item.unit_id];
    end_byte = 27'({in_item.block_number, 9'd0}) + 27'(in_item.length_bytes);
    too_long = 17'(in_item.length_bytes) > 17'(MAX_CHUNKS * CHUNK_BYTES);
    if (!unit_ok) begin
      status = ST_NOT_MOUNTED;
    end else if (in_item.kind == KIND_WRITE && read_only_units[in_item.unit_id]) begin
      status = ST_READ_ONLY;
    end else if (end_byte > {1'b0, disk_size_bytes}) begin
      status = ST_RANGE;
    end else if (too_long) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  // Build the job: start track and sector come straight from the block number.
  always_comb begin
    job_nxt.status        = status;
    job_nxt.single        = (status != ST_OK) || (in_item.length_bytes == 16'd0);
    job_nxt.xlate         = translate_units[in_item.unit_id];
    job_nxt.track         = in_item.block_number[15:3];
    job_nxt.sector        = {in_item.block_number[2:0], 1'b0};
    job_nxt.length        = in_item.length_bytes[14:0];
    job_nxt.memory_base   = in_item.memory_base;
    job_nxt.memory_offset = in_item.memory_offset;
  end

  // The holding register empties as soon as the queue takes its job.
  always_comb begin
    job_valid_nxt = job_valid_r;
    if (accept) begin
      job_valid_nxt = 1'b1;
    end else if (!q_full) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule

[src/dbsm_queue.sv]
// Short job queue between the front and the back end.
// Depends on dbsm_pkg.
module dbsm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  dbsm_pkg::job_t      push_job,
  input  logic                pop,
  output dbsm_pkg::q_status_t q_status,
  output dbsm_pkg::job_t      head_job
);
  import dbsm_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_status.valid = (count_r != '0);
  assign head_job       = mem[rd_ptr_r];
  assign do_push        = push_valid && !q_status.full;
  assign do_pop         = pop && q_status.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/dbsm_back.sv]
// Back end: walks a job chunk by chunk and drives the descriptor register.
// Depends on dbsm_pkg.
module dbsm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dbsm_pkg::q_status_t q_status,
  input  dbsm_pkg::job_t      head_job,
  output logic                pop,
  input  logic [63:0]         skew_table,
  output logic                out_valid,
  input  logic                out_stall,
  output dbsm_pkg::out_item_t out_item
);
  import dbsm_pkg::*;

  logic        active_r, active_nxt;
  logic [1:0]  status_r;
  logic        single_r;
  logic        xlate_r;
  logic [12:0] track_r;
  logic [3:0]  sector_r;
  logic [14:0] rem_r;
  logic [15:0] mbase_r;
  logic [15:0] off_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        emit;
  logic [8:0]  size;
  logic [14:0] rem_nxt;
  logic [3:0]  phys_sector;

  assign pop       = !active_r && q_status.valid;
  assign emit      = active_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Chunk size, remaining count and skewed sector for the current chunk.
  always_comb begin
    size        = (rem_r < 15'(CHUNK_BYTES)) ? rem_r[8:0] : 9'(CHUNK_BYTES);
    rem_nxt     = rem_r - 15'(size);
    phys_sector = xlate_r ? skew_table[{sector_r, 2'b00} +: 4] : sector_r;
  end

  // Descriptor for the current chunk, or the lone descriptor of an
  // error or empty request.
  always_comb begin
    out_item_nxt.status            = status_r;
    out_item_nxt.chunk_memory_base = mbase_r;
    out_item_nxt.chunk_memory_offset = off_r;
    if (single_r) begin
      out_item_nxt.disk_byte_offset = '0;
      out_item_nxt.chunk_bytes      = '0;
      out_item_nxt.last             = 1'b1;
    end else begin
      out_item_nxt.disk_byte_offset = {track_r, phys_sector, 8'h00};
      out_item_nxt.chunk_bytes      = size;
      out_item_nxt.last             = (rem_nxt == '0);
    end
  end

  // Run control: a job is loaded when idle and retired with its last chunk.
  always_comb begin
    active_nxt = active_r;
    if (pop) begin
      active_nxt = 1'b1;
    end else if (emit && out_item_nxt.last) begin
      active_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk state: sector wraps to the next track after fifteen.
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head_job.status;
      single_r <= head_job.single;
      xlate_r  <= head_job.xlate;
      track_r  <= head_job.track;
      sector_r <= head_job.sector;
      rem_r    <= head_job.length;
      mbase_r  <= head_job.memory_base;
      off_r    <= head_job.memory_offset;
    end else if (emit && !single_r) begin
      rem_r    <= rem_nxt;
      off_r    <= off_r + 16'(size);
      sector_r <= sector_r + 4'd1;
      if (sector_r == 4'hF) begin
        track_r <= track_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

[src/disk_block_sector_mapper.sv]
// Top level of the disk block sector mapper: configuration registers and
// the front, queue and back end. Depends on dbsm_pkg and the dbsm_ modules.
//
//  Channel  Direction  Handshake         Payload
//  in_      input      in_valid/in_stall    dbsm_pkg::in_item_t
//  out_     output     out_valid/out_stall  dbsm_pkg::out_item_t
//  cfg_     input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// A request yields one descriptor per 256-byte chunk, one per cycle from the
// back end's walk loop while out_stall is low (up to 64 chunks per request);
// the next job is loaded from the queue only after the last chunk is emitted.
// Accepted requests pass the front's holding register and the queue first.
// Reset is synchronous and active low; it empties the queue and output.
// The two-entry queue lets the front keep accepting while the output stalls.
module disk_block_sector_mapper #(
  parameter int unsigned UNIT_COUNT = 8,
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dbsm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dbsm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import dbsm_pkg::*;

  logic [7:0]  mounted_r;
  logic [7:0]  read_only_r;
  logic [7:0]  translate_r;
  logic [63:0] skew_r;
  logic [25:0] disk_size_r;

  logic        push_valid;
  job_t        push_job;
  job_t        head_job;
  q_status_t   q_status;
  logic        pop;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mounted_r   <= '0;
      read_only_r <= '0;
      translate_r <= '0;
      skew_r      <= '0;
      disk_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOUNTED:   mounted_r   <= cfg_wdata[7:0];
        REG_READ_ONLY: read_only_r <= cfg_wdata[7:0];
        REG_TRANSLATE: translate_r <= cfg_wdata[7:0];
        REG_SKEW:      skew_r      <= cfg_wdata;
        REG_DISK_SIZE: disk_size_r <= cfg_wdata[25:0];
        default: begin
        end
      endcase
    end
  end

  dbsm_front #(
    .UNIT_COUNT(UNIT_COUNT),
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .mounted_units   (mounted_r),
    .read_only_units (read_only_r),
    .translate_units (translate_r),
    .disk_size_bytes (disk_size_r),
    .q_full          (q_status.full),
    .push_valid      (push_valid),
    .push_job        (push_job)
  );

  dbsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .q_status   (q_status),
    .head_job   (head_job)
  );

  dbsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head_job   (head_job),
    .pop        (pop),
    .skew_table (skew_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // An error descriptor is always the lone, empty, final one.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.last && out_item.chunk_bytes == 9'd0)
    else $error("error descriptor is not a single final item");

  // Every chunk but the last of a request is a full chunk.
  a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> out_item.chunk_bytes == 9'(CHUNK_BYTES))
    else $error("short chunk before the end of a request");

  // The back end only loads a job from a non-empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.valid)
    else $error("job loaded from an empty queue");

  // Reset leaves no descriptor pending.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("descriptor pending after reset");

endmodule
